// ----- hw/rtl/ief_pkg.sv -----
// ----------------------------------------------------------------------------
// ief_pkg
// Types, codes and constants shared by the infix expression evaluator.
// ----------------------------------------------------------------------------
package ief_pkg;

  // Input transaction: one character or the end marker
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic signed [63:0] value;
    logic [2:0]         status;
  } out_t;

  // Status codes
  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_BAD_CHAR = 3'd1;
  localparam logic [2:0] STATUS_SYNTAX   = 3'd2;
  localparam logic [2:0] STATUS_DIV_ZERO = 3'd3;
  localparam logic [2:0] STATUS_OVERFLOW = 3'd4;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Largest number literal magnitude
  localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

  // Token classes handed from the front to the back
  typedef enum logic [2:0] {
    TK_DIGIT,
    TK_PLUS,
    TK_MINUS,
    TK_MUL,
    TK_DIV,
    TK_BAD,
    TK_END
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [3:0] digit;
  } tok_t;

  // Pending term operator
  typedef enum logic [1:0] {
    TOP_NONE,
    TOP_MUL,
    TOP_DIV
  } term_op_e;

  // Back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV,
    ST_SAT,
    ST_POST,
    ST_FOLD,
    ST_EMIT
  } state_e;

endpackage

// ----- hw/rtl/infix_expression_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// infix_expression_evaluator_core
// Streaming evaluator of + - * / integer expressions in fixed point.
// ----------------------------------------------------------------------------
// Characters enter one per transaction; an end transaction yields one result
// (value with FRAC_BITS fraction bits, and a status). The front accepts one
// character per cycle into a four-entry token queue while it is not full;
// spaces never enter it. The back takes one token per cycle while idle, but
// completing an operand passes through saturation and term update, first
// through two 32x31 partial products after a multiply or a restoring divider
// (one quotient bit per cycle) after a divide, and on a zero divisor through
// the term update alone, before folding a term into the sum and emitting.
// A stalled result holds the back, which lets the queue fill and stalls input.
module infix_expression_evaluator_core #(
  parameter int FRAC_BITS = 24,
  parameter int ACC_BITS  = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ief_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ief_pkg::out_t out_data_o
);

  logic          push;
  logic          full;
  logic          tok_valid;
  logic          tok_pop;
  ief_pkg::tok_t tok_in;
  ief_pkg::tok_t tok_out;

  ief_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .tok_o      (tok_in),
    .full_i     (full)
  );

  ief_queue #(.DEPTH(4)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tok_i   (tok_in),
    .full_o  (full),
    .valid_o (tok_valid),
    .tok_o   (tok_out),
    .pop_i   (tok_pop)
  );

  ief_back #(.FRAC_BITS(FRAC_BITS), .ACC_BITS(ACC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok_out),
    .tok_pop_o   (tok_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hw/rtl/ief_front.sv -----
// ----------------------------------------------------------------------------
// ief_front
// Accepts characters, drops spaces and classifies the rest into tokens.
// ----------------------------------------------------------------------------
module ief_front (
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ief_pkg::in_t  in_data_i,
  output logic          push_o,
  output ief_pkg::tok_t tok_o,
  input  logic          full_i
);

  logic is_digit;
  logic is_space;

  assign in_stall_o = full_i;

  // Character classification
  always_comb begin
    is_digit  = (in_data_i.char_code >= ief_pkg::CH_ZERO) &&
                (in_data_i.char_code <= ief_pkg::CH_NINE);
    is_space  = (in_data_i.char_code == ief_pkg::CH_SPACE);
    tok_o.digit = 4'(in_data_i.char_code - ief_pkg::CH_ZERO);
    if (in_data_i.end_of_text) begin
      tok_o.kind = ief_pkg::TK_END;
    end else if (is_digit) begin
      tok_o.kind = ief_pkg::TK_DIGIT;
    end else begin
      case (in_data_i.char_code)
        ief_pkg::CH_PLUS:  tok_o.kind = ief_pkg::TK_PLUS;
        ief_pkg::CH_MINUS: tok_o.kind = ief_pkg::TK_MINUS;
        ief_pkg::CH_STAR:  tok_o.kind = ief_pkg::TK_MUL;
        ief_pkg::CH_SLASH: tok_o.kind = ief_pkg::TK_DIV;
        default:           tok_o.kind = ief_pkg::TK_BAD;
      endcase
    end
  end

  // Spaces never reach the queue
  assign push_o = in_valid_i && !full_i && (in_data_i.end_of_text || !is_space);

endmodule

// ----- hw/rtl/ief_queue.sv -----
// ----------------------------------------------------------------------------
// ief_queue
// Small token queue between front and back.
// ----------------------------------------------------------------------------
module ief_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ief_pkg::tok_t tok_i,
  output logic          full_o,
  output logic          valid_o,
  output ief_pkg::tok_t tok_o,
  input  logic          pop_i
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ief_pkg::tok_t entries_q [DEPTH];
  logic [AW:0]   wr_ptr_q, wr_ptr_d;
  logic [AW:0]   rd_ptr_q, rd_ptr_d;

  assign valid_o = (wr_ptr_q != rd_ptr_q);
  assign full_o  = (wr_ptr_q[AW] != rd_ptr_q[AW]) &&
                   (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
  assign tok_o   = entries_q[rd_ptr_q[AW-1:0]];

  assign wr_ptr_d = wr_ptr_q + (AW+1)'(push_i);
  assign rd_ptr_d = rd_ptr_q + (AW+1)'(pop_i && valid_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q[AW-1:0]] <= tok_i;
    end
  end

endmodule

// ----- hw/rtl/ief_back.sv -----
// ----------------------------------------------------------------------------
// ief_back
// Executes tokens: number build-up, term and sum arithmetic, result output.
// ----------------------------------------------------------------------------
module ief_back #(
  parameter int FRAC_BITS = 24,
  parameter int ACC_BITS  = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          tok_valid_i,
  input  ief_pkg::tok_t tok_i,
  output logic          tok_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ief_pkg::out_t out_data_o
);

  localparam int MAG_W = 95;
  localparam logic [MAG_W-1:0] LIM =
    {{(MAG_W-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
  localparam logic [MAG_W-1:0] LIM_P1 = LIM + MAG_W'(1);
  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
  localparam logic [5:0] DIV_LAST = 6'd63;

  ief_pkg::state_e   state_q, state_d;
  ief_pkg::term_op_e top_q, top_d;
  ief_pkg::tok_kind_e pend_q, pend_d;
  logic              phase_q, phase_d;
  logic              negf_q, negf_d;
  logic [30:0]       num_q, num_d;
  logic signed [ACC_BITS-1:0] term_q, term_d;
  logic signed [ACC_BITS-1:0] sum_q, sum_d;
  logic              sumop_q, sumop_d;
  logic [2:0]        err_q, err_d;
  logic [30:0]       mn_q, mn_d;
  logic              neg_q, neg_d;
  logic [MAG_W-1:0]  mag_q, mag_d;
  logic [63:0]       mt_q, mt_d;
  logic [31:0]       rem_q, rem_d;
  logic [5:0]        cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  ief_pkg::out_t     out_q, out_d;

  logic signed [63:0]  term_ext;
  logic [63:0]         term_mag;
  logic                nneg;
  logic [34:0]         num_next;
  logic [31:0]         mul_a;
  logic [62:0]         pp;
  logic [31:0]         rem_sh;
  logic                q_bit;
  logic                neff;
  logic signed [ACC_BITS:0] fold_w;
  logic                load_out;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Shared datapath pieces
  always_comb begin
    term_ext = 64'(term_q);
    term_mag = term_ext[63] ? 64'(-term_ext) : 64'(term_ext);
    nneg     = negf_q && (num_q != '0);
    num_next = 35'(num_q) * 35'd10 + 35'(tok_i.digit);
    mul_a    = (state_q == ief_pkg::ST_MUL_HI) ? mt_q[63:32] : mt_q[31:0];
    pp       = 63'(mul_a) * 63'(mn_q);
    rem_sh   = {rem_q[30:0], mag_q[63]};
    q_bit    = rem_sh >= {1'b0, mn_q};
    neff     = neg_q && (mag_q != '0);
    if (sumop_q) begin
      fold_w = {sum_q[ACC_BITS-1], sum_q} - {term_q[ACC_BITS-1], term_q};
    end else begin
      fold_w = {sum_q[ACC_BITS-1], sum_q} + {term_q[ACC_BITS-1], term_q};
    end
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    pend_d      = pend_q;
    phase_d     = phase_q;
    negf_d      = negf_q;
    num_d       = num_q;
    term_d      = term_q;
    sum_d       = sum_q;
    sumop_d     = sumop_q;
    err_d       = err_q;
    mn_d        = mn_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    mt_d        = mt_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    tok_pop_o   = 1'b0;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ief_pkg::ST_IDLE: begin
        if (tok_valid_i) begin
          tok_pop_o = 1'b1;
          if (tok_i.kind == ief_pkg::TK_END) begin
            if (err_q != ief_pkg::STATUS_OK) begin
              state_d = ief_pkg::ST_EMIT;
            end else if (!phase_q) begin
              err_d   = ief_pkg::STATUS_SYNTAX;
              state_d = ief_pkg::ST_EMIT;
            end else begin
              pend_d = tok_i.kind;
            end
          end else if (err_q == ief_pkg::STATUS_OK) begin
            case (tok_i.kind)
              ief_pkg::TK_DIGIT: begin
                phase_d = 1'b1;
                if (num_next > 35'(ief_pkg::NUM_MAX)) begin
                  num_d = ief_pkg::NUM_MAX;
                  err_d = ief_pkg::STATUS_OVERFLOW;
                end else begin
                  num_d = num_next[30:0];
                end
              end
              ief_pkg::TK_BAD: err_d = ief_pkg::STATUS_BAD_CHAR;
              default: begin
                if (!phase_q) begin
                  if (tok_i.kind == ief_pkg::TK_MINUS) begin
                    negf_d = !negf_q;
                  end else begin
                    err_d = ief_pkg::STATUS_SYNTAX;
                  end
                end else begin
                  pend_d = tok_i.kind;
                end
              end
            endcase
          end

          // Operand complete: apply the pending term operator
          if (err_q == ief_pkg::STATUS_OK && phase_q &&
              tok_i.kind != ief_pkg::TK_DIGIT && tok_i.kind != ief_pkg::TK_BAD) begin
            phase_d = 1'b0;
            negf_d  = 1'b0;
            num_d   = '0;
            mn_d    = num_q;
            mt_d    = term_mag;
            case (top_q)
              ief_pkg::TOP_MUL: begin
                neg_d   = term_ext[63] ^ nneg;
                state_d = ief_pkg::ST_MUL_LO;
              end
              ief_pkg::TOP_DIV: begin
                if (num_q == '0) begin
                  err_d   = ief_pkg::STATUS_DIV_ZERO;
                  state_d = ief_pkg::ST_POST;
                end else begin
                  neg_d   = term_ext[63] ^ nneg;
                  mag_d   = MAG_W'(term_mag);
                  rem_d   = '0;
                  cnt_d   = '0;
                  state_d = ief_pkg::ST_DIV;
                end
              end
              default: begin
                neg_d   = nneg;
                mag_d   = MAG_W'(num_q) << FRAC_BITS;
                state_d = ief_pkg::ST_SAT;
              end
            endcase
          end
        end
      end

      // Product in two 32-bit halves
      ief_pkg::ST_MUL_LO: begin
        mag_d   = MAG_W'(pp);
        state_d = ief_pkg::ST_MUL_HI;
      end
      ief_pkg::ST_MUL_HI: begin
        mag_d   = mag_q + (MAG_W'(pp) << 32);
        state_d = ief_pkg::ST_SAT;
      end

      // Restoring divide, one quotient bit per cycle
      ief_pkg::ST_DIV: begin
        rem_d = q_bit ? (rem_sh - {1'b0, mn_q}) : rem_sh;
        mag_d = MAG_W'({mag_q[62:0], q_bit});
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == DIV_LAST) begin
          state_d = ief_pkg::ST_SAT;
        end
      end

      // Saturate magnitude and sign into the term accumulator
      ief_pkg::ST_SAT: begin
        if (!neff) begin
          if (mag_q > LIM) begin
            term_d = ACC_MAX;
            if (err_q == ief_pkg::STATUS_OK) err_d = ief_pkg::STATUS_OVERFLOW;
          end else begin
            term_d = mag_q[ACC_BITS-1:0];
          end
        end else begin
          if (mag_q > LIM_P1) begin
            term_d = ACC_MIN;
            if (err_q == ief_pkg::STATUS_OK) err_d = ief_pkg::STATUS_OVERFLOW;
          end else begin
            term_d = -mag_q[ACC_BITS-1:0];
          end
        end
        state_d = ief_pkg::ST_POST;
      end

      ief_pkg::ST_POST: begin
        if (err_q != ief_pkg::STATUS_OK) begin
          state_d = (pend_q == ief_pkg::TK_END) ? ief_pkg::ST_EMIT : ief_pkg::ST_IDLE;
        end else begin
          case (pend_q)
            ief_pkg::TK_MUL: begin
              top_d   = ief_pkg::TOP_MUL;
              state_d = ief_pkg::ST_IDLE;
            end
            ief_pkg::TK_DIV: begin
              top_d   = ief_pkg::TOP_DIV;
              state_d = ief_pkg::ST_IDLE;
            end
            default: state_d = ief_pkg::ST_FOLD;
          endcase
        end
      end

      // Add the finished term to the sum, or subtract it after a minus
      ief_pkg::ST_FOLD: begin
        if (fold_w[ACC_BITS] != fold_w[ACC_BITS-1]) begin
          sum_d = fold_w[ACC_BITS] ? ACC_MIN : ACC_MAX;
          err_d = ief_pkg::STATUS_OVERFLOW;
        end else begin
          sum_d = fold_w[ACC_BITS-1:0];
        end
        term_d = '0;
        top_d  = ief_pkg::TOP_NONE;
        if (pend_q == ief_pkg::TK_END) begin
          state_d = ief_pkg::ST_EMIT;
        end else begin
          sumop_d = (pend_q == ief_pkg::TK_MINUS);
          state_d = ief_pkg::ST_IDLE;
        end
      end

      // Hand over the result and start a fresh expression
      ief_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out     = 1'b1;
          out_d.status = err_q;
          out_d.value  = (err_q == ief_pkg::STATUS_OK) ? 64'(sum_q) : '0;
          phase_d      = 1'b0;
          negf_d       = 1'b0;
          num_d        = '0;
          term_d       = '0;
          top_d        = ief_pkg::TOP_NONE;
          sum_d        = '0;
          sumop_d      = 1'b0;
          err_d        = ief_pkg::STATUS_OK;
          state_d      = ief_pkg::ST_IDLE;
        end
      end

      default: state_d = ief_pkg::ST_IDLE;
    endcase

    if (load_out) out_valid_d = 1'b1;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ief_pkg::ST_IDLE;
      top_q       <= ief_pkg::TOP_NONE;
      pend_q      <= ief_pkg::TK_END;
      phase_q     <= 1'b0;
      negf_q      <= 1'b0;
      num_q       <= '0;
      term_q      <= '0;
      sum_q       <= '0;
      sumop_q     <= 1'b0;
      err_q       <= ief_pkg::STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      pend_q      <= pend_d;
      phase_q     <= phase_d;
      negf_q      <= negf_d;
      num_q       <= num_d;
      term_q      <= term_d;
      sum_q       <= sum_d;
      sumop_q     <= sumop_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mn_q  <= mn_d;
    neg_q <= neg_d;
    mag_q <= mag_d;
    mt_q  <= mt_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

endmodule

// ----- hw/rtl/ief_checker.sv -----
// ----------------------------------------------------------------------------
// ief_checker
// Port-level checks of the evaluator results.
// ----------------------------------------------------------------------------
module ief_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input ief_pkg::out_t out_data_o
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Status code stays in its defined range
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ief_pkg::STATUS_OVERFLOW)
    else $error("undefined status code");

  // Any error reports a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ief_pkg::STATUS_OK |-> out_data_o.value == '0)
    else $error("nonzero value with error status");

endmodule

bind infix_expression_evaluator_core ief_checker u_ief_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- test/infix_expression_evaluator_core_test.sv -----
// ----------------------------------------------------------------------------
// infix_expression_evaluator_core_test
// The testbench drives expression text into the evaluator one character per
// transaction and closes each expression with an end transaction. A
// predictor in the bench computes the value and status of each expression,
// and every result is compared with the oldest prediction. Both handshake
// sides idle at random, and one phase holds off the receiver for a long time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module infix_expression_evaluator_core_test;

  localparam int          FRAC     = 24;
  localparam logic [63:0] SUM_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SUM_MIN  = 64'h8000_0000_0000_0000;
  localparam int          WD_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  ief_pkg::in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  ief_pkg::out_t out_data_o;

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit snk_hold = 1'b0;
  int errors = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  ief_pkg::out_t pending_results[$];

  // Evaluator state kept by the predictor
  bit              ev_in_number;
  bit              ev_negate;
  logic [30:0]     ev_number;
  logic signed [63:0] ev_term;
  ief_pkg::term_op_e  ev_term_op;
  logic signed [63:0] ev_sum;
  bit              ev_minus;
  logic [2:0]      ev_status;

  infix_expression_evaluator_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void ev_clear();
    ev_in_number = 0;
    ev_negate = 0;
    ev_number = '0;
    ev_term = '0;
    ev_term_op = ief_pkg::TOP_NONE;
    ev_sum = '0;
    ev_minus = 0;
    ev_status = ief_pkg::STATUS_OK;
  endfunction

  function automatic void ev_flag(logic [2:0] code);
    if (ev_status == ief_pkg::STATUS_OK) ev_status = code;
  endfunction

  function automatic logic [63:0] mag64(logic signed [63:0] x);
    return x < 0 ? -x : x;
  endfunction

  // Clamp a sign and 65-bit magnitude to the accumulator range
  function automatic logic [63:0] clamp(bit neg, logic [64:0] m);
    if (!neg) begin
      if (m > {1'b0, SUM_MAX}) begin
        ev_flag(ief_pkg::STATUS_OVERFLOW);
        return SUM_MAX;
      end
      return m[63:0];
    end
    if (m > {1'b0, SUM_MIN}) begin
      ev_flag(ief_pkg::STATUS_OVERFLOW);
      return SUM_MIN;
    end
    return -m[63:0];
  endfunction

  function automatic void ev_close_operand();
    bit          nneg;
    logic [127:0] prod;
    logic [63:0] mt;
    logic [63:0] q;
    nneg = ev_negate && ev_number != 0;
    mt = mag64(ev_term);
    if (ev_term_op == ief_pkg::TOP_MUL) begin
      prod = mt * {33'd0, ev_number};
      if (prod[127:64] != 0)
        ev_term = clamp((ev_term < 0) != nneg, 65'h1_0000_0000_0000_0000);
      else
        ev_term = clamp(((ev_term < 0) != nneg) && prod != 0, {1'b0, prod[63:0]});
    end else if (ev_term_op == ief_pkg::TOP_DIV) begin
      if (ev_number == 0) begin
        ev_flag(ief_pkg::STATUS_DIV_ZERO);
      end else begin
        q = mt / {33'd0, ev_number};
        ev_term = clamp(((ev_term < 0) != nneg) && q != 0, {1'b0, q});
      end
    end else begin
      ev_term = clamp(nneg, {34'd0, ev_number} << FRAC);
    end
    ev_in_number = 0;
    ev_negate = 0;
    ev_number = '0;
  endfunction

  function automatic void ev_fold();
    logic signed [64:0] s;
    s = ev_minus ? {ev_sum[63], ev_sum} - {ev_term[63], ev_term}
                 : {ev_sum[63], ev_sum} + {ev_term[63], ev_term};
    if (s > $signed({1'b0, SUM_MAX})) begin
      ev_flag(ief_pkg::STATUS_OVERFLOW);
      ev_sum = SUM_MAX;
    end else if (s < $signed({1'b1, SUM_MIN})) begin
      ev_flag(ief_pkg::STATUS_OVERFLOW);
      ev_sum = SUM_MIN;
    end else begin
      ev_sum = s[63:0];
    end
    ev_term = '0;
    ev_term_op = ief_pkg::TOP_NONE;
  endfunction

  // Advance the predictor by one character or end transaction
  function automatic void ev_step(ief_pkg::in_t t);
    ief_pkg::out_t r;
    logic [7:0] c;
    logic [34:0] n;
    c = t.char_code;
    if (t.end_of_text) begin
      if (ev_status == ief_pkg::STATUS_OK) begin
        if (!ev_in_number) ev_flag(ief_pkg::STATUS_SYNTAX);
        else begin
          ev_close_operand();
          if (ev_status == ief_pkg::STATUS_OK) ev_fold();
        end
      end
      r.value = ev_status == ief_pkg::STATUS_OK ? ev_sum : '0;
      r.status = ev_status;
      pending_results.push_back(r);
      ev_clear();
      return;
    end
    if (ev_status != ief_pkg::STATUS_OK || c == ief_pkg::CH_SPACE) return;
    if (c >= ief_pkg::CH_ZERO && c <= ief_pkg::CH_NINE) begin
      n = ev_number * 35'd10 + 35'(c - ief_pkg::CH_ZERO);
      if (n > 35'(ief_pkg::NUM_MAX)) begin
        ev_number = ief_pkg::NUM_MAX;
        ev_flag(ief_pkg::STATUS_OVERFLOW);
      end else begin
        ev_number = n[30:0];
      end
      ev_in_number = 1;
      return;
    end
    if (c != ief_pkg::CH_PLUS && c != ief_pkg::CH_MINUS &&
        c != ief_pkg::CH_STAR && c != ief_pkg::CH_SLASH) begin
      ev_flag(ief_pkg::STATUS_BAD_CHAR);
      return;
    end
    if (!ev_in_number) begin
      if (c == ief_pkg::CH_MINUS) ev_negate = ~ev_negate;
      else ev_flag(ief_pkg::STATUS_SYNTAX);
      return;
    end
    ev_close_operand();
    if (ev_status != ief_pkg::STATUS_OK) return;
    if (c == ief_pkg::CH_STAR) ev_term_op = ief_pkg::TOP_MUL;
    else if (c == ief_pkg::CH_SLASH) ev_term_op = ief_pkg::TOP_DIV;
    else begin
      ev_fold();
      ev_minus = c == ief_pkg::CH_MINUS;
    end
  endfunction

  // Offer one transaction, with random idle cycles in front
  task automatic send_item(logic [7:0] c, bit eot);
    ief_pkg::in_t t;
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    t.char_code = c;
    t.end_of_text = eot;
    in_valid_i <= 1'b1;
    in_data_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    ev_step(t);
    items_sent++;
  endtask

  task automatic send_text(string s);
    foreach (s[k]) send_item(s[k], 1'b0);
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_char();
    case ($urandom_range(9))
      0, 1, 2, 3: return 8'(ief_pkg::CH_ZERO + $urandom_range(9));
      4:       return ief_pkg::CH_SPACE;
      5:       return ief_pkg::CH_PLUS;
      6:       return ief_pkg::CH_MINUS;
      7:       return ief_pkg::CH_STAR;
      8:       return ief_pkg::CH_SLASH;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly well-formed expression with random operands and operators; now and then a random character precedes the end
  task automatic send_expression();
    int nops;
    int nd;
    nops = $urandom_range(4);
    for (int k = 0; k <= nops; k++) begin
      repeat ($urandom_range(2) == 0 ? $urandom_range(3) : 0)
        send_item(ief_pkg::CH_MINUS, 1'b0);
      nd = $urandom_range(9) == 0 ? $urandom_range(12) + 1 : $urandom_range(3) + 1;
      repeat (nd) begin
        if ($urandom_range(15) == 0) send_item(ief_pkg::CH_SPACE, 1'b0);
        send_item(8'(ief_pkg::CH_ZERO + $urandom_range(9)), 1'b0);
      end
      if (k < nops) begin
        case ($urandom_range(3))
          0: send_item(ief_pkg::CH_PLUS, 1'b0);
          1: send_item(ief_pkg::CH_MINUS, 1'b0);
          2: send_item(ief_pkg::CH_STAR, 1'b0);
          default: send_item(ief_pkg::CH_SLASH, 1'b0);
        endcase
      end
    end
    if ($urandom_range(19) == 0) send_item(rand_char(), 1'b0);
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_random(int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(9) < 8) begin
        send_expression();
      end else begin
        repeat ($urandom_range(6)) send_item(rand_char(), 1'b0);
        send_item(8'($urandom_range(255)), 1'b1);
      end
    end
  endtask

  task automatic test_directed();
    send_text("1+2*3");
    send_text("7 - 1 0 / 4");
    send_text("--5*-3");
    send_text("");
    send_text("*3");
    send_text("4+");
    send_text("5/0");
    send_text("2147483647*2147483647*2147483647");
    send_text("99999999999");
    send_text("3&4");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    send_text("-");
    send_text("0-2147483647*549755813");
  endtask

  task automatic test_idle_patterns();
    src_idle_pct = 23;
    snk_idle_pct = 70;
    send_random(500);
    src_idle_pct = 70;
    snk_idle_pct = 23;
    send_random(500);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_random(500);
  endtask

  // Receiver holds off while characters keep coming
  task automatic test_backpressure();
    snk_hold = 1'b1;
    send_random(120);
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (snk_hold) begin
      repeat (400) @(posedge clk_i);
      snk_hold <= 1'b0;
    end
  end

  // Receiver stall pattern
  always @(posedge clk_i) begin
    out_stall_i <= snk_hold || ($urandom_range(99) < snk_idle_pct);
  end

  // Result checking
  always @(posedge clk_i) begin
    ief_pkg::out_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: value %h status %0d", $time,
                 out_data_o.value, out_data_o.status);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data_o.value !== exp_r.value) begin
          $display("%0t: value expected %h actual %h", $time, exp_r.value,
                   out_data_o.value);
          errors++;
        end
        if (out_data_o.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   out_data_o.status);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WD_LIMIT) begin
      $display("infix_expression_evaluator_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    ev_clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    test_backpressure();
    test_idle_patterns();
    wait_drained();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("infix_expression_evaluator_core_test OK");
    end else begin
      $display("infix_expression_evaluator_core_test NOT OK");
    end
    $finish;
  end

endmodule
